// ===== hdl/dtq_pkg.sv =====
// package for the deadline task queue: sizes, codes and shared types
// used by dtq_cell and deadline_task_queue_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

    // store size and derived widths
    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int TIME_W   = 64;
    localparam int ORDER_W  = 64;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 2;
    localparam int OCNT_W   = 5;

    // command codes
    localparam logic CMD_POST = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] RK_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] RK_POP     = 2'd1;
    localparam logic [KIND_W-1:0] RK_SUMMARY = 2'd2;

    // post status
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    // one stored task
    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [ORDER_W-1:0]  order;
        logic [HANDLE_W-1:0] handle;
        logic                kind;
    } entry_t;

    // best entry seen so far, handed down the cell row
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        entry_t            ent;
    } cand_t;

endpackage

`default_nettype wire

// ===== hdl/dtq_cell.sv =====
// one queue slot: holds a task and merges it into the passing best-candidate word
// depends on dtq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtq_cell
    import dtq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cell_idx,
    input  wire logic             wr_en,
    input  wire logic             clr_en,
    input  wire entry_t           wr_data,
    input  wire cand_t            cand_in,
    output logic                  valid,
    output cand_t                 cand_out
);

    logic   valid_reg;
    entry_t ent_reg;
    cand_t  cand_reg;
    cand_t  cand_next;
    logic   take_own;

    // slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= 1'b1;
        end
        else if (clr_en)
        begin
            valid_reg <= 1'b0;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg <= wr_data;
        end
    end

    // earlier target wins, equal targets go by lower order number
    always_comb
    begin
        take_own = valid_reg &&
                   (!cand_in.found ||
                    (ent_reg.deadline < cand_in.ent.deadline) ||
                    ((ent_reg.deadline == cand_in.ent.deadline) &&
                     (ent_reg.order < cand_in.ent.order)));
        cand_next = cand_in;
        if (take_own)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.ent   = ent_reg;
        end
    end

    // hand-off register to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    assign valid    = valid_reg;
    assign cand_out = cand_reg;

endmodule

`default_nettype wire

// ===== hdl/deadline_task_queue_core.sv =====
// deadline task queue top level: command sequencer over a row of dtq_cell slots
// depends on dtq_pkg and dtq_cell
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   A command word is taken at a rising edge with start high and busy low.
//   cmd = post stores the task in the lowest free slot and answers with one
//   acknowledge word (status full when all slots are taken). cmd = poll pops
//   every task whose target is not later than time_value, earliest target
//   first, ties by posting order, one word each, then one summary word.
//   Every result word is shown for one cycle with strobe high; last marks the
//   final word of a command. The receiver cannot stall the block, so words
//   are never held back.
//   Search: each search is a wave that walks the cell row, one cell per
//   cycle, and ends in the decision state. A post runs one search before
//   its acknowledge; a poll that pops n tasks runs n + 1 searches. busy
//   stays high until the last word has been shown; one command is in
//   flight at a time.
//   Reset empties all slots and zeroes the order counter; slot payloads are
//   not cleared.

module deadline_task_queue_core
    import dtq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                cmd,
    input  wire logic [TIME_W-1:0]   time_value,
    input  wire logic [HANDLE_W-1:0] task_handle,
    input  wire logic                task_kind,
    output logic                     strobe,
    output logic [KIND_W-1:0]        result_kind,
    output logic                     status,
    output logic [HANDLE_W-1:0]      popped_handle,
    output logic                     popped_kind,
    output logic [OCNT_W-1:0]        ran_count,
    output logic [TIME_W-1:0]        next_deadline,
    output logic [OCNT_W-1:0]        pending_count,
    output logic                     last
);

    state_t              state_reg, state_next;
    logic                cmd_reg;
    logic [TIME_W-1:0]   time_reg;
    logic                status_reg, status_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    ran_reg, ran_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;

    logic                accept;
    logic                full;
    logic                due;
    logic [DEPTH-1:0]    valid_vec;
    logic [DEPTH-1:0]    wr_vec;
    logic [DEPTH-1:0]    clr_vec;
    logic [IDX_W-1:0]    free_idx;
    logic                do_post;
    logic                do_pop;
    entry_t              wr_data;
    cand_t               chain [DEPTH+1];
    cand_t               best;

    assign accept = start && (state_reg == S_IDLE);
    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign best   = chain[DEPTH];
    assign due    = best.found && (best.ent.deadline <= time_reg);

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_vec[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // slot write and clear selects
    assign do_post = accept && (cmd == CMD_POST) && !full;
    assign do_pop  = (state_reg == S_DECIDE) && (cmd_reg == CMD_POLL) && due;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            wr_vec[i]  = do_post && (free_idx == IDX_W'(i));
            clr_vec[i] = do_pop && (best.idx == IDX_W'(i));
        end
    end

    assign wr_data.deadline = time_value;
    assign wr_data.order    = order_reg;
    assign wr_data.handle   = task_handle;
    assign wr_data.kind     = task_kind;

    // cell row, the search wave enters empty at the head
    assign chain[0] = '0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        dtq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .wr_en    (wr_vec[g]),
            .clr_en   (clr_vec[g]),
            .wr_data  (wr_data),
            .cand_in  (chain[g]),
            .valid    (valid_vec[g]),
            .cand_out (chain[g+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = do_pop ? S_SCAN : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // counters and command fields
    always_comb
    begin
        status_next = status_reg;
        order_next  = order_reg;
        cnt_next    = cnt_reg;
        ran_next    = ran_reg;
        scan_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ran_next    = '0;
                    status_next = ST_OK;
                    if (cmd == CMD_POST)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            order_next = order_reg + 1'b1;
                            cnt_next   = cnt_reg + 1'b1;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
            end
            S_DECIDE:
            begin
                if (do_pop)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    ran_next = ran_reg + 1'b1;
                end
            end
            default:
            begin
                scan_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            order_reg  <= '0;
            cnt_reg    <= '0;
            ran_reg    <= '0;
            scan_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            order_reg  <= order_next;
            cnt_reg    <= cnt_next;
            ran_reg    <= ran_next;
            scan_reg   <= scan_next;
            status_reg <= status_next;
        end
    end

    // command word payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            time_reg <= time_value;
        end
    end

    // result word
    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        strobe        = 1'b0;
        result_kind   = RK_ACK;
        status        = ST_OK;
        popped_handle = '0;
        popped_kind   = 1'b0;
        ran_count     = '0;
        next_deadline = '0;
        pending_count = '0;
        last          = 1'b0;
        case (state_reg)
            S_DECIDE:
            begin
                strobe = 1'b1;
                if (cmd_reg == CMD_POST)
                begin
                    result_kind   = RK_ACK;
                    status        = status_reg;
                    next_deadline = best.found ? best.ent.deadline : '0;
                    pending_count = OCNT_W'(cnt_reg);
                    last          = 1'b1;
                end
                else if (due)
                begin
                    result_kind   = RK_POP;
                    popped_handle = best.ent.handle;
                    popped_kind   = best.ent.kind;
                    ran_count     = OCNT_W'(ran_reg + 1'b1);
                    pending_count = OCNT_W'(cnt_reg - 1'b1);
                end
                else
                begin
                    result_kind   = RK_SUMMARY;
                    ran_count     = OCNT_W'(ran_reg);
                    next_deadline = best.found ? best.ent.deadline : '0;
                    pending_count = OCNT_W'(cnt_reg);
                    last          = 1'b1;
                end
            end
            default:
            begin
                strobe = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_deadline_task_queue_core.sv =====
// testbench for deadline_task_queue_core: drives post and poll words, predicts every
// result word from a shadow copy of the task store and checks each strobed word
// depends on dtq_pkg and the deadline_task_queue_core rtl
`timescale 1ns / 1ps

module tb_deadline_task_queue_core;

    import dtq_pkg::*;

    // one expected result word
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic                stat;
        logic [HANDLE_W-1:0] handle;
        logic                pkind;
        logic [OCNT_W-1:0]   ran;
        logic [TIME_W-1:0]   next_due;
        logic [OCNT_W-1:0]   pending;
        logic                is_last;
    } result_word_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                cmd;
    logic [TIME_W-1:0]   time_value;
    logic [HANDLE_W-1:0] task_handle;
    logic                task_kind;
    logic                strobe;
    logic [KIND_W-1:0]   result_kind;
    logic                status;
    logic [HANDLE_W-1:0] popped_handle;
    logic                popped_kind;
    logic [OCNT_W-1:0]   ran_count;
    logic [TIME_W-1:0]   next_deadline;
    logic [OCNT_W-1:0]   pending_count;
    logic                last;

    // shadow task store
    logic                shadow_valid [DEPTH];
    logic [TIME_W-1:0]   shadow_due [DEPTH];
    logic [ORDER_W-1:0]  shadow_order [DEPTH];
    logic [HANDLE_W-1:0] shadow_handle [DEPTH];
    logic                shadow_kind [DEPTH];
    logic [ORDER_W-1:0]  shadow_next_order;

    result_word_t expected_words [$];
    result_word_t oldest_word;
    int           mismatches;
    int           words_sent;
    bit           idle_enable;

    deadline_task_queue_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .time_value    (time_value),
        .task_handle   (task_handle),
        .task_kind     (task_kind),
        .strobe        (strobe),
        .result_kind   (result_kind),
        .status        (status),
        .popped_handle (popped_handle),
        .popped_kind   (popped_kind),
        .ran_count     (ran_count),
        .next_deadline (next_deadline),
        .pending_count (pending_count),
        .last          (last)
    );

    // clock, 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // slot that comes first by target, then by posting order; -1 when empty
    function automatic int shadow_first_slot();
        int best;
        best = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (shadow_valid[i] && (best < 0 || shadow_due[i] < shadow_due[best] ||
                (shadow_due[i] == shadow_due[best] &&
                 shadow_order[i] < shadow_order[best])))
                best = i;
        end
        return best;
    endfunction

    function automatic logic [TIME_W-1:0] shadow_earliest();
        int b;
        b = shadow_first_slot();
        return (b < 0) ? '0 : shadow_due[b];
    endfunction

    function automatic logic [OCNT_W-1:0] shadow_held();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            n += shadow_valid[i] ? 1 : 0;
        return OCNT_W'(n);
    endfunction

    // append one word at the tail of the expected list
    task automatic add_expected(input result_word_t w);
        expected_words.insert(expected_words.size(), w);
    endtask

    // update the shadow store for one accepted word and queue its results
    task automatic predict_queue_words(input logic c, input logic [TIME_W-1:0] tv,
                                       input logic [HANDLE_W-1:0] h, input logic k);
        result_word_t w;
        int           slot;
        int           ran;
        int           b;
        if (c == CMD_POST)
        begin
            slot = -1;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (slot < 0 && !shadow_valid[i])
                    slot = i;
            end
            w.stat = ST_FULL;
            if (slot >= 0)
            begin
                shadow_valid[slot]  = 1'b1;
                shadow_due[slot]    = tv;
                shadow_order[slot]  = shadow_next_order;
                shadow_handle[slot] = h;
                shadow_kind[slot]   = k;
                shadow_next_order   = shadow_next_order + 1'b1;
                w.stat = ST_OK;
            end
            w.kind     = RK_ACK;
            w.handle   = '0;
            w.pkind    = 1'b0;
            w.ran      = '0;
            w.next_due = shadow_earliest();
            w.pending  = shadow_held();
            w.is_last  = 1'b1;
            add_expected(w);
        end
        else
        begin
            ran = 0;
            b = shadow_first_slot();
            while (b >= 0 && shadow_due[b] <= tv)
            begin
                shadow_valid[b] = 1'b0;
                ran++;
                w.kind     = RK_POP;
                w.stat     = ST_OK;
                w.handle   = shadow_handle[b];
                w.pkind    = shadow_kind[b];
                w.ran      = OCNT_W'(ran);
                w.next_due = '0;
                w.pending  = shadow_held();
                w.is_last  = 1'b0;
                add_expected(w);
                b = shadow_first_slot();
            end
            w.kind     = RK_SUMMARY;
            w.stat     = ST_OK;
            w.handle   = '0;
            w.pkind    = 1'b0;
            w.ran      = OCNT_W'(ran);
            w.next_due = shadow_earliest();
            w.pending  = shadow_held();
            w.is_last  = 1'b1;
            add_expected(w);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch, got %0h expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    // result checker, samples each strobed word at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, result_kind", 64'(result_kind), '0);
            else
            begin
                oldest_word = expected_words.pop_front();
                if (result_kind !== oldest_word.kind)
                    report_mismatch("result_kind", 64'(result_kind),
                                    64'(oldest_word.kind));
                if (status !== oldest_word.stat)
                    report_mismatch("status", 64'(status), 64'(oldest_word.stat));
                if (popped_handle !== oldest_word.handle)
                    report_mismatch("popped_handle", 64'(popped_handle),
                                    64'(oldest_word.handle));
                if (popped_kind !== oldest_word.pkind)
                    report_mismatch("popped_kind", 64'(popped_kind),
                                    64'(oldest_word.pkind));
                if (ran_count !== oldest_word.ran)
                    report_mismatch("ran_count", 64'(ran_count), 64'(oldest_word.ran));
                if (next_deadline !== oldest_word.next_due)
                    report_mismatch("next_deadline", next_deadline, oldest_word.next_due);
                if (pending_count !== oldest_word.pending)
                    report_mismatch("pending_count", 64'(pending_count),
                                    64'(oldest_word.pending));
                if (last !== oldest_word.is_last)
                    report_mismatch("last", 64'(last), 64'(oldest_word.is_last));
            end
        end
    end

    // send one command word and wait until it is taken
    task automatic send_word(input logic c, input logic [TIME_W-1:0] tv,
                             input logic [HANDLE_W-1:0] h, input logic k);
        start       <= 1'b1;
        cmd         <= c;
        time_value  <= tv;
        task_handle <= h;
        task_kind   <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_queue_words(c, tv, h, k);
        words_sent++;
    endtask

    // random sender idling
    task automatic sender_gap();
        if (idle_enable && $urandom_range(0, 99) < 35)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24))
                @(posedge clk);
        end
    endtask

    // hold off until every expected word has come
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // mix of tiny, extreme and full-range times so ties and partial pops occur
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return {$urandom, $urandom};
            default: return TIME_W'($urandom_range(0, 40));
        endcase
    endfunction

    // polls on an empty store, at both time extremes
    task automatic test_empty_poll();
        send_word(CMD_POLL, '0, 16'hffff, 1'b1);
        sender_gap();
        send_word(CMD_POLL, '1, 16'h0000, 1'b0);
        sender_gap();
    endtask

    // fill every slot with ties and extreme targets, overflow once, then drain
    task automatic test_fill_full_and_drain();
        logic [TIME_W-1:0] due;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 4)
                0: due = '0;
                1: due = '1;
                2: due = 64'd500;
                default: due = 64'h8000_0000_0000_0000;
            endcase
            send_word(CMD_POST, due, (i % 2) ? 16'(65535 - i) : 16'(i), i[0]);
            sender_gap();
        end
        // store is full, this one is dropped
        send_word(CMD_POST, 64'd1, 16'hbeef, 1'b1);
        sender_gap();
        // pops only the targets at zero
        send_word(CMD_POLL, '0, 16'h0000, 1'b0);
        sender_gap();
        // pops everything left
        send_word(CMD_POLL, '1, 16'hffff, 1'b1);
        sender_gap();
    endtask

    // random post batches followed by polls, with some full-range noise
    task automatic test_random_traffic(input int n_words);
        int goal;
        int n_posts;
        goal = words_sent + n_words;
        while (words_sent < goal)
        begin
            // long stretch with no idling in the middle of the run
            idle_enable = !(words_sent > goal - n_words + 80 && words_sent < goal - 100);
            n_posts = $urandom_range(0, 19);
            for (int i = 0; i < n_posts; i++)
            begin
                send_word(CMD_POST, pick_time(), 16'($urandom), 1'($urandom));
                sender_gap();
            end
            repeat ($urandom_range(1, 3))
            begin
                send_word(CMD_POLL, pick_time(), 16'($urandom), 1'($urandom));
                sender_gap();
            end
            if ($urandom_range(0, 9) == 0)
                wait_until_drained();
        end
        idle_enable = 1'b1;
    endtask

    // stimulus sequence
    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= CMD_POST;
        time_value  <= '0;
        task_handle <= '0;
        task_kind   <= 1'b0;
        mismatches        = 0;
        words_sent        = 0;
        idle_enable       = 1'b1;
        shadow_next_order = '0;
        for (int i = 0; i < DEPTH; i++)
            shadow_valid[i] = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_poll();
        test_fill_full_and_drain();
        wait_until_drained();
        test_random_traffic(280);

        wait_until_drained();
        repeat (DEPTH + 4)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb_deadline_task_queue_core OK");
        else
            $display("tb_deadline_task_queue_core NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("tb_deadline_task_queue_core NOT OK");
        $finish;
    end

endmodule
